/* rtl/midi_sustain_and_cc_dispatch_top_assert.svh */
// Assertion macros for the MIDI sustain and controller dispatch block.
// Included by the top level; relies on nothing else.
`ifndef MIDI_SUSTAIN_AND_CC_DISPATCH_TOP_ASSERT_SVH
`define MIDI_SUSTAIN_AND_CC_DISPATCH_TOP_ASSERT_SVH

// Same-cycle implication under a synchronous reset.
`define MSCD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("midi dispatch: same-cycle check failed");

// Next-cycle implication under a synchronous reset.
`define MSCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("midi dispatch: next-cycle check failed");

`endif

/* rtl/midi_scd_pkg.sv */
// Package for the MIDI sustain and controller dispatch block.
// Holds request and event codes, register indexes, controller numbers, value limits and the sequencer state type.
`default_nettype none
package midi_scd_pkg;

   localparam logic [2:0] REQ_NOTE_ON  = 3'd0;
   localparam logic [2:0] REQ_NOTE_OFF = 3'd1;
   localparam logic [2:0] REQ_BEND     = 3'd2;
   localparam logic [2:0] REQ_CTRL     = 3'd3;
   localparam logic [2:0] REQ_PRESSURE = 3'd4;
   localparam logic [2:0] REQ_LEARN    = 3'd5;
   localparam logic [2:0] REQ_UNMAP    = 3'd6;

   localparam logic [2:0] EV_NOTE_ON  = 3'd0;
   localparam logic [2:0] EV_NOTE_OFF = 3'd1;
   localparam logic [2:0] EV_BEND     = 3'd2;
   localparam logic [2:0] EV_PARAM    = 3'd3;
   localparam logic [2:0] EV_MOD      = 3'd4;
   localparam logic [2:0] EV_TUNE     = 3'd5;
   localparam logic [2:0] EV_TOUCH    = 3'd6;
   localparam logic [2:0] EV_ALL_OFF  = 3'd7;

   localparam logic CSR_LISTEN = 1'b0;
   localparam logic CSR_BEND   = 1'b1;

   localparam logic [6:0] CC_MOD      = 7'd1;
   localparam logic [6:0] CC_P5       = 7'd5;
   localparam logic [6:0] CC_TUNE     = 7'd6;
   localparam logic [6:0] CC_P7       = 7'd7;
   localparam logic [6:0] CC_P16      = 7'd16;
   localparam logic [6:0] CC_P17      = 7'd17;
   localparam logic [6:0] CC_P18      = 7'd18;
   localparam logic [6:0] CC_SUSTAIN  = 7'd64;
   localparam logic [6:0] CC_P71      = 7'd71;
   localparam logic [6:0] CC_P74      = 7'd74;
   localparam logic [6:0] CC_SOUND_OFF = 7'd120;
   localparam logic [6:0] CC_NOTES_OFF = 7'd123;

   localparam logic [6:0] VAL_MAX      = 7'd127;
   localparam logic [6:0] VAL_HALF     = 7'd64;
   localparam logic [4:0] RANGE_MAX    = 5'd24;
   localparam logic signed [14:0] BEND_CENTER = 15'sd8192;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_SHIFT = 6'b000100,
      ST_MAPRD = 6'b001000,
      ST_EMIT  = 6'b010000,
      ST_FLUSH = 6'b100000
   } state_type;

endpackage
`default_nettype wire

/* rtl/midi_sustain_and_cc_dispatch_top.sv */
// Usage: MIDI channel messages come in on the req_ channel as beats, one beat at a
// time. Each beat yields zero or more result beats on the rsp_ channel; the final one
// of a burst carries rsp_last. req_stall is low only while the sequencer is idle.
// A simple event passes from the pending register into the rsp_ register, and the
// next request is taken once the sequencer is back in idle. A note-on scans the held
// list entry by entry and, when it finds the note, compacts it one moved entry at a
// time. A pedal-down note-off scans the list the same way. Releasing the pedal plays
// out the held list one note at a time, and a mapped controller waits for the map
// memory read. The registered read port of the held-note memory paces the scan,
// compaction and play-out.
// The rsp_ output register holds its beat while rsp_stall is high, and the
// sequencer waits for it. Configuration writes on the csr_ channel are always
// taken and should only be issued while the block is idle.
// Reset clears the pedal, learning, held count and controller map; listen channel
// returns to zero and bend range to two.
// Depends on midi_scd_pkg and the assertion header.
`default_nettype none
`include "midi_sustain_and_cc_dispatch_top_assert.svh"
module midi_sustain_and_cc_dispatch_top #(
   parameter int MAX_HELD   = 64,
   parameter int NUM_PARAMS = 256
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [2:0]  req_type,
   input  wire  [4:0]  req_midi_channel,
   input  wire  [7:0]  req_key,
   input  wire  [13:0] req_data_value,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [2:0]  rsp_event_kind,
   output logic [7:0]  rsp_event_code,
   output logic signed [18:0] rsp_event_value,
   output logic        rsp_last,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_index,
   input  wire  [4:0]  csr_data
);

   localparam int CNT_W  = $clog2(MAX_HELD + 1);
   localparam int ADDR_W = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;

   midi_scd_pkg::state_type state_ff, state_in;

   logic [4:0]  listen_ff, listen_in;
   logic [4:0]  range_ff, range_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic        phase_ff, phase_in;
   logic        pedal_ff, pedal_in;
   logic        learning_ff, learning_in;
   logic [7:0]  target_ff, target_in;
   logic        mode_on_ff, mode_on_in;
   logic        then_mod_ff, then_mod_in;
   logic [6:0]  note_ff, note_in;
   logic [6:0]  val_ff, val_in;
   logic [2:0]  pend_kind_ff, pend_kind_in;
   logic [7:0]  pend_code_ff, pend_code_in;
   logic signed [18:0] pend_value_ff, pend_value_in;
   logic        pend_last_ff, pend_last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_code_ff, rsp_code_in;
   logic signed [18:0] rsp_value_ff, rsp_value_in;
   logic        rsp_last_ff, rsp_last_in;
   logic [127:0] map_valid_ff, map_valid_in;

   logic [6:0]  held_mem [MAX_HELD];
   logic [6:0]  held_rd_ff;
   logic        held_we;
   logic [ADDR_W-1:0] held_wa, held_ra;
   logic [6:0]  held_wd;
   logic [7:0]  map_mem [128];
   logic [7:0]  map_rd_ff;
   logic        map_we;

   logic        accept, out_free, filtered;
   logic [6:0]  k7, v7;
   logic [4:0]  range_c;
   logic signed [14:0] bend_off;
   logic signed [20:0] bend_prod;
   logic [CNT_W-1:0] idx_next;

   always_comb begin
      k7       = req_key[6:0];
      v7       = (req_data_value > {7'd0, midi_scd_pkg::VAL_MAX}) ? midi_scd_pkg::VAL_MAX
                                                                  : req_data_value[6:0];
      range_c  = (range_ff > midi_scd_pkg::RANGE_MAX) ? midi_scd_pkg::RANGE_MAX : range_ff;
      bend_off = $signed({1'b0, req_data_value}) - midi_scd_pkg::BEND_CENTER;
      bend_prod = 21'(bend_off) * 21'($signed({1'b0, range_c}));
      filtered = (req_type <= midi_scd_pkg::REQ_PRESSURE) && (listen_ff != 5'd0)
                 && (req_midi_channel != listen_ff);
      accept   = req_valid && !req_stall;
      out_free = !rsp_valid_ff || !rsp_stall;
      idx_next = idx_ff + CNT_W'(1);
   end

   always_comb begin
      state_in      = state_ff;
      listen_in     = listen_ff;
      range_in      = range_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      phase_in      = phase_ff;
      pedal_in      = pedal_ff;
      learning_in   = learning_ff;
      target_in     = target_ff;
      mode_on_in    = mode_on_ff;
      then_mod_in   = then_mod_ff;
      note_in       = note_ff;
      val_in        = val_ff;
      pend_kind_in  = pend_kind_ff;
      pend_code_in  = pend_code_ff;
      pend_value_in = pend_value_ff;
      pend_last_in  = pend_last_ff;
      map_valid_in  = map_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      held_we = 1'b0;
      held_wa = idx_ff[ADDR_W-1:0];
      held_wd = note_ff;
      held_ra = idx_ff[ADDR_W-1:0];
      map_we  = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            midi_scd_pkg::CSR_LISTEN: listen_in = csr_data;
            midi_scd_pkg::CSR_BEND:   range_in  = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         midi_scd_pkg::ST_IDLE: begin
            if (accept && !filtered) begin
               note_in      = k7;
               val_in       = v7;
               idx_in       = '0;
               phase_in     = 1'b0;
               then_mod_in  = 1'b0;
               pend_code_in = 8'd0;
               pend_last_in = 1'b1;
               pend_value_in = 19'({12'd0, v7});
               unique case (req_type)
                  midi_scd_pkg::REQ_NOTE_ON, midi_scd_pkg::REQ_NOTE_OFF: begin
                     mode_on_in = (req_type == midi_scd_pkg::REQ_NOTE_ON) && (v7 != 7'd0);
                     if (mode_on_in || pedal_ff) begin
                        state_in = midi_scd_pkg::ST_SCAN;
                     end else begin
                        pend_kind_in  = midi_scd_pkg::EV_NOTE_OFF;
                        pend_code_in  = {1'b0, k7};
                        pend_value_in = '0;
                        state_in      = midi_scd_pkg::ST_EMIT;
                     end
                  end
                  midi_scd_pkg::REQ_BEND: begin
                     pend_kind_in  = midi_scd_pkg::EV_BEND;
                     pend_value_in = bend_prod[18:0];
                     state_in      = midi_scd_pkg::ST_EMIT;
                  end
                  midi_scd_pkg::REQ_PRESSURE: begin
                     pend_kind_in = midi_scd_pkg::EV_TOUCH;
                     state_in     = midi_scd_pkg::ST_EMIT;
                  end
                  midi_scd_pkg::REQ_LEARN: begin
                     if ({1'b0, req_key} < 9'(NUM_PARAMS)) begin
                        learning_in = 1'b1;
                        target_in   = req_key;
                     end
                  end
                  midi_scd_pkg::REQ_UNMAP: map_valid_in[k7] = 1'b0;
                  midi_scd_pkg::REQ_CTRL: begin
                     if (learning_ff) begin
                        map_we          = 1'b1;
                        map_valid_in[k7] = 1'b1;
                        learning_in     = 1'b0;
                        target_in       = 8'd0;
                     end else if (map_valid_ff[k7]) begin
                        state_in = midi_scd_pkg::ST_MAPRD;
                     end else begin
                        unique case (k7)
                           midi_scd_pkg::CC_MOD: begin
                              pend_kind_in = midi_scd_pkg::EV_PARAM;
                              pend_code_in = {1'b0, k7};
                              pend_last_in = 1'b0;
                              then_mod_in  = 1'b1;
                              state_in     = midi_scd_pkg::ST_EMIT;
                           end
                           midi_scd_pkg::CC_P5, midi_scd_pkg::CC_P7, midi_scd_pkg::CC_P16,
                           midi_scd_pkg::CC_P17, midi_scd_pkg::CC_P18, midi_scd_pkg::CC_P71,
                           midi_scd_pkg::CC_P74: begin
                              pend_kind_in = midi_scd_pkg::EV_PARAM;
                              pend_code_in = {1'b0, k7};
                              state_in     = midi_scd_pkg::ST_EMIT;
                           end
                           midi_scd_pkg::CC_TUNE: begin
                              pend_kind_in  = midi_scd_pkg::EV_TUNE;
                              pend_value_in = $signed(19'({12'd0, v7})) - 19'sd64;
                              state_in      = midi_scd_pkg::ST_EMIT;
                           end
                           midi_scd_pkg::CC_SUSTAIN: begin
                              pedal_in = (v7 >= midi_scd_pkg::VAL_HALF);
                              if (pedal_ff && !pedal_in && count_ff != '0) begin
                                 state_in = midi_scd_pkg::ST_FLUSH;
                              end
                           end
                           midi_scd_pkg::CC_SOUND_OFF, midi_scd_pkg::CC_NOTES_OFF: begin
                              pend_kind_in  = midi_scd_pkg::EV_ALL_OFF;
                              pend_value_in = '0;
                              count_in      = '0;
                              state_in      = midi_scd_pkg::ST_EMIT;
                           end
                           default: ;
                        endcase
                     end
                  end
                  default: ;
               endcase
            end
         end
         midi_scd_pkg::ST_SCAN: begin
            if (!phase_ff) begin
               if (idx_ff >= count_ff) begin
                  if (mode_on_ff) begin
                     pend_kind_in  = midi_scd_pkg::EV_NOTE_ON;
                     pend_code_in  = {1'b0, note_ff};
                     pend_value_in = 19'({12'd0, val_ff});
                     state_in      = midi_scd_pkg::ST_EMIT;
                  end else if (count_ff < CNT_W'(MAX_HELD)) begin
                     held_we  = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                     state_in = midi_scd_pkg::ST_IDLE;
                  end else begin
                     pend_kind_in  = midi_scd_pkg::EV_NOTE_OFF;
                     pend_code_in  = {1'b0, note_ff};
                     pend_value_in = '0;
                     state_in      = midi_scd_pkg::ST_EMIT;
                  end
               end else begin
                  phase_in = 1'b1;
               end
            end else begin
               phase_in = 1'b0;
               if (held_rd_ff == note_ff) begin
                  state_in = mode_on_ff ? midi_scd_pkg::ST_SHIFT : midi_scd_pkg::ST_IDLE;
               end else begin
                  idx_in = idx_next;
               end
            end
         end
         midi_scd_pkg::ST_SHIFT: begin
            held_ra = idx_next[ADDR_W-1:0];
            if (!phase_ff) begin
               if (idx_next >= count_ff) begin
                  count_in      = count_ff - CNT_W'(1);
                  pend_kind_in  = midi_scd_pkg::EV_NOTE_ON;
                  pend_code_in  = {1'b0, note_ff};
                  pend_value_in = 19'({12'd0, val_ff});
                  state_in      = midi_scd_pkg::ST_EMIT;
               end else begin
                  phase_in = 1'b1;
               end
            end else begin
               held_we  = 1'b1;
               held_wd  = held_rd_ff;
               idx_in   = idx_next;
               phase_in = 1'b0;
            end
         end
         midi_scd_pkg::ST_MAPRD: begin
            pend_kind_in = midi_scd_pkg::EV_PARAM;
            pend_code_in = map_rd_ff;
            state_in     = midi_scd_pkg::ST_EMIT;
         end
         midi_scd_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_code_in  = pend_code_ff;
               rsp_value_in = pend_value_ff;
               rsp_last_in  = pend_last_ff;
               if (then_mod_ff) begin
                  then_mod_in  = 1'b0;
                  pend_kind_in = midi_scd_pkg::EV_MOD;
                  pend_code_in = 8'd0;
                  pend_last_in = 1'b1;
               end else begin
                  state_in = midi_scd_pkg::ST_IDLE;
               end
            end
         end
         midi_scd_pkg::ST_FLUSH: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = midi_scd_pkg::EV_NOTE_OFF;
               rsp_code_in  = {1'b0, held_rd_ff};
               rsp_value_in = '0;
               rsp_last_in  = (idx_next == count_ff);
               idx_in       = idx_next;
               phase_in     = 1'b0;
               if (idx_next == count_ff) begin
                  count_in = '0;
                  state_in = midi_scd_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = midi_scd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (held_we) begin
         held_mem[held_wa] <= held_wd;
      end
      held_rd_ff <= held_mem[held_ra];
      if (map_we) begin
         map_mem[k7] <= target_ff;
      end
      map_rd_ff <= map_mem[k7];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= midi_scd_pkg::ST_IDLE;
         listen_ff    <= 5'd0;
         range_ff     <= 5'd2;
         count_ff     <= '0;
         idx_ff       <= '0;
         phase_ff     <= 1'b0;
         pedal_ff     <= 1'b0;
         learning_ff  <= 1'b0;
         target_ff    <= 8'd0;
         then_mod_ff  <= 1'b0;
         map_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         listen_ff    <= listen_in;
         range_ff     <= range_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         phase_ff     <= phase_in;
         pedal_ff     <= pedal_in;
         learning_ff  <= learning_in;
         target_ff    <= target_in;
         then_mod_ff  <= then_mod_in;
         map_valid_ff <= map_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_on_ff    <= mode_on_in;
      note_ff       <= note_in;
      val_ff        <= val_in;
      pend_kind_ff  <= pend_kind_in;
      pend_code_ff  <= pend_code_in;
      pend_value_ff <= pend_value_in;
      pend_last_ff  <= pend_last_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall       = (state_ff != midi_scd_pkg::ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_event_code  = rsp_code_ff;
   assign rsp_event_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

   `MSCD_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_HELD))
   `MSCD_ASSERT_SAME(a_flush_nonempty, clock, reset, state_ff == midi_scd_pkg::ST_FLUSH, count_ff != '0 && !pedal_ff)
   `MSCD_ASSERT_NEXT(a_learn_clears, clock, reset, accept && !filtered && req_type == midi_scd_pkg::REQ_CTRL && learning_ff, !learning_ff && map_valid_ff[$past(k7)])
   `MSCD_ASSERT_SAME(a_mod_follows_param, clock, reset, then_mod_ff, state_ff == midi_scd_pkg::ST_EMIT && pend_kind_ff == midi_scd_pkg::EV_PARAM)

endmodule
`default_nettype wire

/* dv/midi_sustain_and_cc_dispatch_top_tb.sv */
// Self-checking testbench for the MIDI sustain and controller dispatch block.
// Predicts each result beat in its own model and checks it field by field.
// Depends on midi_scd_pkg and the block's top level.
`default_nettype none
module midi_sustain_and_cc_dispatch_top_tb;

   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         code;
      logic signed [18:0] value;
      logic               last;
   } event_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_type = '0;
   logic [4:0] req_midi_channel = '0;
   logic [7:0] req_key = '0;
   logic [13:0] req_data_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_event_kind;
   logic [7:0] rsp_event_code;
   logic signed [18:0] rsp_event_value;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [4:0] csr_data = '0;

   midi_sustain_and_cc_dispatch_top dut (.*);

   // Shadow state of the dispatcher.
   logic [4:0] listen_ch;
   logic [4:0] bend_semis;
   logic [6:0] held_list [$];
   logic pedal;
   logic arm_learn;
   logic [7:0] arm_target;
   logic cc_mapped [128];
   logic [7:0] cc_param [128];

   event_beat_type pending_events [$];
   int errors = 0;
   int cycles = 0;
   bit idle_on = 1'b1;
   bit hold_rsp = 1'b0;
   localparam int CYCLE_LIMIT = 400000;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** midi_sustain_and_cc_dispatch_top: FAILED **");
         $finish;
      end
   end

   task automatic push_event(ref event_beat_type burst[$], input logic [2:0] kind,
         input logic [7:0] code, input int value);
      event_beat_type e;
      e.kind = kind;
      e.code = code;
      e.value = value[18:0];
      e.last = 1'b0;
      burst.insert(burst.size(), e);
   endtask

   task automatic release_note(ref event_beat_type burst[$], input logic [6:0] note);
      int hits[$];
      if (pedal) begin
         hits = held_list.find_index with (item == note);
         if (hits.size() > 0) return;
         if (held_list.size() < 64) begin
            held_list.insert(held_list.size(), note);
            return;
         end
      end
      push_event(burst, midi_scd_pkg::EV_NOTE_OFF, {1'b0, note}, 0);
   endtask

   task automatic predict_dispatch(input logic [2:0] typ, input logic [4:0] ch,
         input logic [7:0] key, input logic [13:0] data);
      event_beat_type burst[$];
      logic [6:0] k7;
      int v7;
      int hits[$];
      k7 = key[6:0];
      v7 = (data > 127) ? 127 : data;
      if (typ <= midi_scd_pkg::REQ_PRESSURE && listen_ch != 0 && ch != listen_ch) return;
      case (typ)
         midi_scd_pkg::REQ_NOTE_ON: begin
            if (v7 == 0) release_note(burst, k7);
            else begin
               hits = held_list.find_index with (item == k7);
               if (hits.size() > 0) held_list.delete(hits[0]);
               push_event(burst, midi_scd_pkg::EV_NOTE_ON, {1'b0, k7}, v7);
            end
         end
         midi_scd_pkg::REQ_NOTE_OFF: release_note(burst, k7);
         midi_scd_pkg::REQ_BEND: push_event(burst, midi_scd_pkg::EV_BEND, 8'd0,
               (int'(data) - 8192) * ((bend_semis > 24) ? 24 : int'(bend_semis)));
         midi_scd_pkg::REQ_CTRL: begin
            if (arm_learn) begin
               cc_mapped[k7] = 1'b1;
               cc_param[k7] = arm_target;
               arm_learn = 1'b0;
               arm_target = '0;
            end else if (cc_mapped[k7]) begin
               push_event(burst, midi_scd_pkg::EV_PARAM, cc_param[k7], v7);
            end else begin
               case (k7)
                  midi_scd_pkg::CC_MOD: begin
                     push_event(burst, midi_scd_pkg::EV_PARAM, 8'd1, v7);
                     push_event(burst, midi_scd_pkg::EV_MOD, 8'd0, v7);
                  end
                  midi_scd_pkg::CC_P5, midi_scd_pkg::CC_P7, midi_scd_pkg::CC_P16,
                  midi_scd_pkg::CC_P17, midi_scd_pkg::CC_P18, midi_scd_pkg::CC_P71,
                  midi_scd_pkg::CC_P74:
                     push_event(burst, midi_scd_pkg::EV_PARAM, {1'b0, k7}, v7);
                  midi_scd_pkg::CC_TUNE:
                     push_event(burst, midi_scd_pkg::EV_TUNE, 8'd0, v7 - 64);
                  midi_scd_pkg::CC_SUSTAIN: begin
                     if (pedal && v7 < 64) begin
                        foreach (held_list[i])
                           push_event(burst, midi_scd_pkg::EV_NOTE_OFF,
                                 {1'b0, held_list[i]}, 0);
                        held_list.delete();
                     end
                     pedal = (v7 >= 64);
                  end
                  midi_scd_pkg::CC_SOUND_OFF, midi_scd_pkg::CC_NOTES_OFF: begin
                     push_event(burst, midi_scd_pkg::EV_ALL_OFF, 8'd0, 0);
                     held_list.delete();
                  end
                  default: ;
               endcase
            end
         end
         midi_scd_pkg::REQ_PRESSURE: push_event(burst, midi_scd_pkg::EV_TOUCH, 8'd0, v7);
         midi_scd_pkg::REQ_LEARN: begin
            arm_learn = 1'b1;
            arm_target = key;
         end
         midi_scd_pkg::REQ_UNMAP: cc_mapped[k7] = 1'b0;
         default: ;
      endcase
      if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
      foreach (burst[i]) pending_events.insert(pending_events.size(), burst[i]);
   endtask

   task automatic idle_gap();
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic send_request(input logic [2:0] typ, input logic [4:0] ch,
         input logic [7:0] key, input logic [13:0] data);
      idle_gap();
      req_valid <= 1'b1;
      req_type <= typ;
      req_midi_channel <= ch;
      req_key <= key;
      req_data_value <= data;
      do @(posedge clock); while (req_stall);
      predict_dispatch(typ, ch, key, data);
   endtask

   task automatic write_csr(input logic idx, input logic [4:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == midi_scd_pkg::CSR_LISTEN) listen_ch = val;
      else bend_semis = val;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_events.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // Receiver: random stall bursts, checks each accepted beat.
   initial begin
      event_beat_type exp_ev;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (pending_events.size() == 0) begin
               $error("unexpected result beat kind %0d", rsp_event_kind);
               errors++;
            end else begin
               exp_ev = pending_events.pop_front();
               if (rsp_event_kind !== exp_ev.kind) begin
                  $error("event_kind expected %0d actual %0d", exp_ev.kind, rsp_event_kind);
                  errors++;
               end
               if (rsp_event_code !== exp_ev.code) begin
                  $error("event_code expected %0d actual %0d", exp_ev.code, rsp_event_code);
                  errors++;
               end
               if (rsp_event_value !== exp_ev.value) begin
                  $error("event_value expected %0d actual %0d", exp_ev.value,
                        rsp_event_value);
                  errors++;
               end
               if (rsp_last !== exp_ev.last) begin
                  $error("last expected %0d actual %0d", exp_ev.last, rsp_last);
                  errors++;
               end
            end
         end
         if (hold_rsp) rsp_stall <= 1'b1;
         else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16) - 1) begin
               @(posedge clock);
               if (rsp_valid && !rsp_stall) errors++;
            end
         end else rsp_stall <= 1'b0;
      end
   end

   task automatic test_directed();
      send_request(midi_scd_pkg::REQ_NOTE_ON, 5'd1, 8'd60, 14'd100);
      send_request(midi_scd_pkg::REQ_NOTE_ON, 5'd1, 8'd200, 14'd16383);
      send_request(midi_scd_pkg::REQ_NOTE_ON, 5'd1, 8'd61, 14'd0);
      send_request(midi_scd_pkg::REQ_NOTE_OFF, 5'd16, 8'd255, 14'd0);
      send_request(midi_scd_pkg::REQ_BEND, 5'd1, 8'd0, 14'd0);
      send_request(midi_scd_pkg::REQ_BEND, 5'd1, 8'd0, 14'd16383);
      send_request(midi_scd_pkg::REQ_PRESSURE, 5'd2, 8'd0, 14'd9000);
      send_request(midi_scd_pkg::REQ_CTRL, 5'd1, 8'd1, 14'd127);
      send_request(midi_scd_pkg::REQ_CTRL, 5'd1, 8'd6, 14'd0);
      send_request(midi_scd_pkg::REQ_CTRL, 5'd1, 8'd74, 14'd55);
      send_request(midi_scd_pkg::REQ_CTRL, 5'd1, 8'd64, 14'd127);
      send_request(midi_scd_pkg::REQ_NOTE_OFF, 5'd1, 8'd40, 14'd0);
      send_request(midi_scd_pkg::REQ_NOTE_OFF, 5'd1, 8'd41, 14'd0);
      send_request(midi_scd_pkg::REQ_NOTE_OFF, 5'd1, 8'd40, 14'd0);
      send_request(midi_scd_pkg::REQ_NOTE_ON, 5'd1, 8'd40, 14'd90);
      send_request(midi_scd_pkg::REQ_CTRL, 5'd1, 8'd64, 14'd0);
      send_request(midi_scd_pkg::REQ_CTRL, 5'd1, 8'd123, 14'd0);
      send_request(midi_scd_pkg::REQ_LEARN, 5'd0, 8'd255, 14'd0);
      send_request(midi_scd_pkg::REQ_CTRL, 5'd1, 8'd64, 14'd70);
      send_request(midi_scd_pkg::REQ_CTRL, 5'd1, 8'd64, 14'd10);
      send_request(midi_scd_pkg::REQ_UNMAP, 5'd31, 8'd192, 14'd0);
      send_request(3'd7, 5'd1, 8'd1, 14'd1);
      wait_drained();
   endtask

   task automatic test_held_list_full();
      send_request(midi_scd_pkg::REQ_CTRL, 5'd3, 8'd64, 14'd127);
      for (int i = 0; i < 66; i++)
         send_request(midi_scd_pkg::REQ_NOTE_OFF, 5'd3, 8'(i), 14'd0);
      send_request(midi_scd_pkg::REQ_NOTE_ON, 5'd3, 8'd10, 14'd5);
      send_request(midi_scd_pkg::REQ_CTRL, 5'd3, 8'd120, 14'd0);
      send_request(midi_scd_pkg::REQ_CTRL, 5'd3, 8'd64, 14'd0);
      wait_drained();
   endtask

   task automatic test_config_sweep();
      write_csr(midi_scd_pkg::CSR_LISTEN, 5'd5);
      write_csr(midi_scd_pkg::CSR_BEND, 5'd31);
      for (int i = 0; i < 8; i++)
         send_request(3'($urandom_range(0, 4)), 5'($urandom_range(4, 6)),
               8'($urandom), 14'($urandom));
      send_request(midi_scd_pkg::REQ_LEARN, 5'd9, 8'd7, 14'd0);
      wait_drained();
      write_csr(midi_scd_pkg::CSR_LISTEN, 5'd31);
      write_csr(midi_scd_pkg::CSR_BEND, 5'd0);
      send_request(midi_scd_pkg::REQ_BEND, 5'd31, 8'd0, 14'd100);
      send_request(midi_scd_pkg::REQ_CTRL, 5'd2, 8'd1, 14'd3);
      wait_drained();
      write_csr(midi_scd_pkg::CSR_LISTEN, 5'd16);
      write_csr(midi_scd_pkg::CSR_BEND, 5'd24);
      send_request(midi_scd_pkg::REQ_BEND, 5'd16, 8'd0, 14'd0);
      send_request(midi_scd_pkg::REQ_CTRL, 5'd16, 8'd1, 14'd3);
      wait_drained();
      write_csr(midi_scd_pkg::CSR_LISTEN, 5'd0);
      write_csr(midi_scd_pkg::CSR_BEND, 5'd2);
   endtask

   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 12; i++)
            send_request(midi_scd_pkg::REQ_PRESSURE, 5'd1, 8'd0, 14'(i));
      join
      wait_drained();
   endtask

   task automatic random_item();
      logic [7:0] cc_pick [12] = '{1, 5, 6, 7, 16, 17, 18, 64, 71, 74, 120, 123};
      logic [7:0] k;
      logic [2:0] t;
      int r;
      r = $urandom_range(0, 99);
      k = 8'($urandom_range(30, 45)) | 8'($urandom_range(0, 1) << 7);
      if (r < 30) t = midi_scd_pkg::REQ_NOTE_OFF;
      else if (r < 55) t = midi_scd_pkg::REQ_NOTE_ON;
      else if (r < 80) t = midi_scd_pkg::REQ_CTRL;
      else t = 3'($urandom_range(0, 7));
      if (t == midi_scd_pkg::REQ_CTRL && $urandom_range(0, 3) != 0)
         k = cc_pick[$urandom_range(0, 11)] | 8'($urandom_range(0, 1) << 7);
      else if (t >= midi_scd_pkg::REQ_BEND) k = 8'($urandom);
      send_request(t, 5'($urandom_range(0, 31)), k,
            ($urandom_range(0, 4) == 0) ? 14'($urandom) : 14'($urandom_range(0, 127)));
   endtask

   task automatic test_random();
      for (int i = 0; i < 60; i++) random_item();
      wait_drained();
      idle_on = 1'b0;
      for (int i = 0; i < 33; i++) random_item();
      wait_drained();
   endtask

   initial begin
      listen_ch = '0;
      bend_semis = 5'd2;
      pedal = 1'b0;
      arm_learn = 1'b0;
      arm_target = '0;
      foreach (cc_mapped[i]) cc_mapped[i] = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_held_list_full();
      test_config_sweep();
      test_backpressure();
      test_random();
      if (errors == 0 && pending_events.size() == 0)
         $display("** midi_sustain_and_cc_dispatch_top: PASSED **");
      else
         $display("** midi_sustain_and_cc_dispatch_top: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire
